### hdl/aod_pkg.sv
// package for the agentx object identifier decoder
// word types, phase and error codes, prefix expansion table; no dependencies
package aod_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } aod_in_t;

  typedef struct packed {
    logic [31:0] subid_value;
    logic        value_present;
    logic        last_of_oid;
    logic        include_flag;
    logic [1:0]  error_code;
  } aod_out_t;

  typedef struct packed {
    logic     valid;
    aod_out_t word;
  } aod_res_t;

  typedef enum logic [4:0] {
    PH_COUNT    = 5'b00001,
    PH_PREFIX   = 5'b00010,
    PH_INCLUDE  = 5'b00100,
    PH_RESERVED = 5'b01000,
    PH_WORDS    = 5'b10000
  } aod_phase_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_SHORT   = 2'd1,
    ERR_INCLUDE = 2'd2
  } aod_err_e;

  localparam logic [2:0] EXP_LAST     = 3'd4;
  localparam logic [1:0] BYTE_LAST    = 2'd3;

  // internet prefix 1.3.6.1 followed by the prefix byte
  function automatic logic [31:0] aod_exp_value(input logic [2:0] k, input logic [7:0] prefix);
    logic [31:0] v;
    case (k)
      3'd0:    v = 32'd1;
      3'd1:    v = 32'd3;
      3'd2:    v = 32'd6;
      3'd3:    v = 32'd1;
      default: v = {24'd0, prefix};
    endcase
    return v;
  endfunction

endpackage

### hdl/aod_decode.sv
// header and subidentifier decoder with prefix expansion counter
// depends on aod_pkg
module aod_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  aod_pkg::aod_in_t item_i,
  input  logic            big_endian_i,
  input  logic            can_load_i,
  output aod_pkg::aod_res_t res_o,
  output logic            consume_o
);

  aod_pkg::aod_phase_e phase_q, phase_d;
  logic [7:0]  words_left_q, words_left_d;
  logic [7:0]  prefix_q, prefix_d;
  logic        include_q, include_d;
  logic [1:0]  biw_q, biw_d;
  logic [23:0] acc_q, acc_d;
  logic [2:0]  exp_cnt_q;

  logic done;
  logic advance;

  always_comb begin
    logic       endb;
    logic [7:0] b;
    logic       none;
    logic       final_byte;
    logic       fail;
    logic       restart;
    logic [1:0] fcode;
    endb         = item_i.buffer_end;
    b            = item_i.data_byte;
    none         = (words_left_q == 8'd0);
    final_byte   = (words_left_q <= 8'd1) && (biw_q == aod_pkg::BYTE_LAST);
    fail         = 1'b0;
    restart      = 1'b0;
    fcode        = aod_pkg::ERR_NONE;
    done         = 1'b1;
    res_o        = '0;
    phase_d      = phase_q;
    words_left_d = words_left_q;
    prefix_d     = prefix_q;
    include_d    = include_q;
    biw_d        = biw_q;
    acc_d        = acc_q;
    if (item_valid_i) begin
      case (phase_q)
        aod_pkg::PH_COUNT: begin
          if (endb) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_SHORT;
          end else begin
            words_left_d = b;
            phase_d      = aod_pkg::PH_PREFIX;
          end
        end
        aod_pkg::PH_PREFIX: begin
          if (endb) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_SHORT;
          end else begin
            prefix_d = b;
            phase_d  = aod_pkg::PH_INCLUDE;
          end
        end
        aod_pkg::PH_INCLUDE: begin
          if (endb) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_SHORT;
          end else if (b[7:1] != 7'd0) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_INCLUDE;
          end else begin
            include_d = b[0];
            phase_d   = aod_pkg::PH_RESERVED;
          end
        end
        aod_pkg::PH_RESERVED: begin
          if (!none && endb) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_SHORT;
          end else begin
            if (prefix_q != 8'd0) begin
              res_o.valid              = 1'b1;
              res_o.word.subid_value   = aod_pkg::aod_exp_value(exp_cnt_q, prefix_q);
              res_o.word.value_present = 1'b1;
              res_o.word.last_of_oid   = (exp_cnt_q == aod_pkg::EXP_LAST) && none;
              res_o.word.include_flag  = include_q;
              done                     = (exp_cnt_q == aod_pkg::EXP_LAST);
            end else if (none) begin
              res_o.valid             = 1'b1;
              res_o.word.last_of_oid  = 1'b1;
              res_o.word.include_flag = include_q;
            end
            if (none) begin
              restart = 1'b1;
            end else begin
              phase_d = aod_pkg::PH_WORDS;
              biw_d   = 2'd0;
              acc_d   = 24'd0;
            end
          end
        end
        aod_pkg::PH_WORDS: begin
          if (endb && !final_byte) begin
            fail  = 1'b1;
            fcode = aod_pkg::ERR_SHORT;
          end else if (biw_q != aod_pkg::BYTE_LAST) begin
            if (big_endian_i) begin
              acc_d = {acc_q[15:0], b};
            end else begin
              case (biw_q)
                2'd0:    acc_d = {acc_q[23:8], b};
                2'd1:    acc_d = {acc_q[23:16], b, acc_q[7:0]};
                default: acc_d = {b, acc_q[15:0]};
              endcase
            end
            biw_d = biw_q + 2'd1;
          end else begin
            res_o.valid              = 1'b1;
            res_o.word.subid_value   = big_endian_i ? {acc_q, b} : {b, acc_q};
            res_o.word.value_present = 1'b1;
            res_o.word.last_of_oid   = (words_left_q <= 8'd1);
            res_o.word.include_flag  = include_q;
            biw_d                    = 2'd0;
            acc_d                    = 24'd0;
            if (words_left_q <= 8'd1) begin
              restart = 1'b1;
            end else begin
              words_left_d = words_left_q - 8'd1;
            end
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (fail) begin
        res_o                  = '0;
        res_o.valid            = 1'b1;
        res_o.word.last_of_oid = 1'b1;
        res_o.word.error_code  = fcode;
        done                   = 1'b1;
        restart                = 1'b1;
      end
      if (restart) begin
        phase_d      = aod_pkg::PH_COUNT;
        words_left_d = 8'd0;
        prefix_d     = 8'd0;
        include_d    = 1'b0;
        biw_d        = 2'd0;
        acc_d        = 24'd0;
      end
    end
  end

  assign advance   = item_valid_i && (!res_o.valid || can_load_i);
  assign consume_o = advance && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= aod_pkg::PH_COUNT;
      words_left_q <= 8'd0;
      prefix_q     <= 8'd0;
      include_q    <= 1'b0;
      biw_q        <= 2'd0;
      acc_q        <= 24'd0;
      exp_cnt_q    <= 3'd0;
    end else if (advance) begin
      if (done) begin
        phase_q      <= phase_d;
        words_left_q <= words_left_d;
        prefix_q     <= prefix_d;
        include_q    <= include_d;
        biw_q        <= biw_d;
        acc_q        <= acc_d;
        exp_cnt_q    <= 3'd0;
      end else begin
        exp_cnt_q <= exp_cnt_q + 3'd1;
      end
    end
  end

  a_exp_in_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_cnt_q != 3'd0 |-> phase_q == aod_pkg::PH_RESERVED && prefix_q != 8'd0)
    else $error("expansion counter running outside reserved phase");

  a_words_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == aod_pkg::PH_WORDS |-> words_left_q != 8'd0)
    else $error("word phase with no words left");

  a_biw_in_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    biw_q != 2'd0 |-> phase_q == aod_pkg::PH_WORDS)
    else $error("byte position set outside word phase");

  a_error_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_o && res_o.valid && res_o.word.error_code != aod_pkg::ERR_NONE
    |=> phase_q == aod_pkg::PH_COUNT && exp_cnt_q == 3'd0)
    else $error("error did not return to header");

endmodule

### hdl/aod_out_reg.sv
// result register between decoder and output channel
// depends on aod_pkg
module aod_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aod_pkg::aod_res_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aod_pkg::aod_out_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  aod_pkg::aod_out_t out_q;
  logic              load;

  assign can_load_o = !out_valid_q || out_ready_i;
  assign load       = res_i.valid && can_load_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/agentx_oid_decoder_unit.sv
// agentx object identifier decoder, top level: input register, config register
// depends on aod_pkg, aod_decode, aod_out_reg
//
// Takes the encoded identifier one byte word per cycle and gives one result word
// per subidentifier through the input register and the result register. A
// reserved byte with a non-zero prefix holds the input register while the
// expansion counter steps through 1.3.6.1.prefix. The result register
// stalls the input only when it is full and not taken.
module agentx_oid_decoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aod_pkg::aod_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aod_pkg::aod_out_t out_data_o
);

  logic              big_endian_q;
  logic              in_valid_q, in_valid_d;
  aod_pkg::aod_in_t  in_q;
  logic              accept;
  logic              consume;
  logic              can_load;
  aod_pkg::aod_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b1;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !in_valid_q || consume;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  aod_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .big_endian_i (big_endian_q),
    .can_load_i   (can_load),
    .res_o        (res),
    .consume_o    (consume)
  );

  aod_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
